FILE: rtl/pebd_pkg.sv
`timescale 1ns / 1ps

package pebd_pkg;

  localparam int TICK_BITS  = 32;
  localparam int GAP_W      = 7;
  localparam int STEP_W     = 16;
  localparam int EV_TICK_W  = 32;
  localparam int OUT_DATA_W = 56;

  localparam logic [1:0] REG_STEP_BITS = 2'd0;
  localparam logic [1:0] REG_GAP_BITS  = 2'd1;
  localparam logic [1:0] REG_SIGN_MAG  = 2'd2;

  localparam logic [2:0] STEP_BITS_RST = 3'd2;
  localparam logic [2:0] GAP_BITS_RST  = 3'd6;
  localparam logic       SIGN_MAG_RST  = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic STATUS_EVENT = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef logic [TICK_BITS-1:0] tick_t;

  typedef struct packed {
    logic [2:0] step_bits;
    logic [2:0] gap_bits;
    logic       sign_mag_mode;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] packed_byte;
  } item_t;

  typedef struct packed {
    logic [GAP_W-1:0]     gap_ticks;
    logic [STEP_W-1:0]    step_sum;
    logic [EV_TICK_W-1:0] event_tick;
    logic                 status;
    logic                 last_flag;
  } result_t;

  function automatic logic [STEP_W-1:0] decode_step(logic [7:0] b, cfg_t c);
    logic [7:0]        mask;
    logic [7:0]        raw;
    logic [7:0]        top;
    logic [7:0]        mag;
    logic [STEP_W-1:0] res;
    mask = (8'h01 << c.step_bits) - 8'h01;
    raw  = b & mask;
    top  = 8'h01 << (c.step_bits - 3'd1);
    mag  = raw & (top - 8'h01);
    if (c.step_bits == 3'd0) begin
      res = '0;
    end else if (c.sign_mag_mode) begin
      if ((raw & top) != 8'h00) begin
        res = 16'h0000 - {8'h00, mag};
      end else begin
        res = {8'h00, mag};
      end
    end else if ((raw & top) != 8'h00) begin
      res = {8'hFF, raw | ~mask};
    end else begin
      res = {8'h00, raw};
    end
    return res;
  endfunction

  function automatic logic [GAP_W-1:0] decode_gap(logic [7:0] b, cfg_t c);
    logic [7:0] sh;
    logic [7:0] gmask;
    logic [7:0] g;
    sh    = b >> c.step_bits;
    gmask = (8'h01 << c.gap_bits) - 8'h01;
    g     = sh & gmask;
    return g[GAP_W-1:0];
  endfunction

endpackage

FILE: rtl/pebd_cfg_regs.sv
`timescale 1ns / 1ps

module pebd_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [2:0]        cfg_data,
  output pebd_pkg::cfg_t    cfg
);

  pebd_pkg::cfg_t cfg_r;
  pebd_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        pebd_pkg::REG_STEP_BITS: cfg_nxt.step_bits     = cfg_data;
        pebd_pkg::REG_GAP_BITS:  cfg_nxt.gap_bits      = cfg_data;
        pebd_pkg::REG_SIGN_MAG:  cfg_nxt.sign_mag_mode = cfg_data[0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_bits     <= pebd_pkg::STEP_BITS_RST;
      cfg_r.gap_bits      <= pebd_pkg::GAP_BITS_RST;
      cfg_r.sign_mag_mode <= pebd_pkg::SIGN_MAG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/pebd_in_stage.sv
`timescale 1ns / 1ps

module pebd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pebd_pkg::item_t   in_item,
  output logic              s1_valid,
  input  logic              s1_take,
  output pebd_pkg::item_t   s1_item
);

  logic            valid_r;
  logic            valid_nxt;
  pebd_pkg::item_t item_r;

  assign in_ready = !valid_r || s1_take;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (s1_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: rtl/pebd_core.sv
`timescale 1ns / 1ps

module pebd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  pebd_pkg::cfg_t    cfg,
  input  logic              s1_valid,
  output logic              s1_take,
  input  pebd_pkg::item_t   s1_item,
  output logic              out_valid,
  input  logic              out_ready,
  output pebd_pkg::result_t out_res
);

  logic                              pend_v_r;
  logic                              pend_v_nxt;
  logic [pebd_pkg::GAP_W-1:0]        pend_gap_r;
  logic [pebd_pkg::GAP_W-1:0]        pend_gap_nxt;
  logic [pebd_pkg::STEP_W-1:0]       pend_step_r;
  logic [pebd_pkg::STEP_W-1:0]       pend_step_nxt;
  pebd_pkg::tick_t                   tick_r;
  pebd_pkg::tick_t                   tick_nxt;
  logic                              ov_r;
  logic                              ov_nxt;
  pebd_pkg::result_t                 res_r;
  pebd_pkg::result_t                 res_nxt;
  logic                              emit;

  logic [pebd_pkg::STEP_W-1:0]       step;
  logic [pebd_pkg::GAP_W-1:0]        gap;
  logic [pebd_pkg::TICK_BITS:0]      tick_sum;

  assign s1_take   = s1_valid && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_res   = res_r;

  assign step     = pebd_pkg::decode_step(s1_item.packed_byte, cfg);
  assign gap      = pebd_pkg::decode_gap(s1_item.packed_byte, cfg);
  assign tick_sum = {1'b0, tick_r} + (pebd_pkg::TICK_BITS + 1)'(gap);

  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_gap_nxt  = pend_gap_r;
    pend_step_nxt = pend_step_r;
    tick_nxt      = tick_r;
    emit          = 1'b0;
    res_nxt.gap_ticks  = pend_gap_r;
    res_nxt.step_sum   = pend_step_r;
    res_nxt.event_tick = pebd_pkg::EV_TICK_W'(tick_r);
    res_nxt.status     = pebd_pkg::STATUS_EVENT;
    res_nxt.last_flag  = 1'b0;
    if (s1_take) begin
      if (s1_item.kind == pebd_pkg::KIND_END) begin
        emit              = 1'b1;
        res_nxt.last_flag = 1'b1;
        if (!pend_v_r) begin
          res_nxt.gap_ticks  = '0;
          res_nxt.step_sum   = '0;
          res_nxt.event_tick = '0;
          res_nxt.status     = pebd_pkg::STATUS_EMPTY;
        end
        pend_v_nxt    = 1'b0;
        pend_gap_nxt  = '0;
        pend_step_nxt = '0;
        tick_nxt      = '0;
      end else if (gap == '0) begin
        if (pend_v_r) begin
          pend_step_nxt = pend_step_r + step;
        end
      end else begin
        emit          = pend_v_r;
        pend_v_nxt    = 1'b1;
        pend_gap_nxt  = gap;
        pend_step_nxt = step;
        tick_nxt      = tick_sum[pebd_pkg::TICK_BITS] ? '1
                                                      : tick_sum[pebd_pkg::TICK_BITS-1:0];
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      pend_gap_r  <= '0;
      pend_step_r <= '0;
      tick_r      <= '0;
      ov_r        <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      pend_gap_r  <= pend_gap_nxt;
      pend_step_r <= pend_step_nxt;
      tick_r      <= tick_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: rtl/packed_event_byte_decoder.sv
`timescale 1ns / 1ps
// Packed event byte decoder.
// Input stream (in_*): one request per byte; in_tuser is the kind (0 data byte,
// 1 end of stream), in_tdata is the packed byte. A data byte with a nonzero gap
// releases the previously pending event; a zero-gap byte merges its step into
// the pending event. End of stream releases the pending event with tlast set,
// or a no-events status, and clears the event state.
// Result stream (out_*): tdata carries gap, merged step and cumulative tick;
// tuser is the status, tlast closes the stream.
// Config port (cfg_*): index 0 step width, 1 gap width, 2 sign-magnitude
// mode; always ready, write only while the stream is idle.
// Order: a releasing request is registered in the input register, then its
// result is loaded into the result register once that register is free or
// being taken. Throughput: one byte per cycle while the result stream does not
// stall, set by the combinational decode and state update.
// Reset clears the event state and loads config defaults (2, 6, 1).
// When out_tready is low with a result waiting, the result register holds,
// the next byte holds in the input register and in_tready drops once that
// register is occupied.
module packed_event_byte_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] packed_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [pebd_pkg::OUT_DATA_W-1:0] out_tdata,
                                  // [6:0] gap_ticks, [22:7] step_sum, [54:23] event_tick
  output logic        out_tuser,  // [0] status
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  pebd_pkg::cfg_t    cfg;
  pebd_pkg::item_t   in_item;
  pebd_pkg::item_t   s1_item;
  pebd_pkg::result_t res;
  logic              s1_valid;
  logic              s1_take;

  assign in_item.kind        = in_tuser;
  assign in_item.packed_byte = in_tdata;

  pebd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pebd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s1_item  (s1_item)
  );

  pebd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_take   (s1_take),
    .s1_item   (s1_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {1'b0, res.event_tick, res.step_sum, res.gap_ticks};
  assign out_tuser = res.status;
  assign out_tlast = res.last_flag;

endmodule

FILE: tb/packed_event_byte_decoder_tb.sv
`timescale 1ns / 1ps

module packed_event_byte_decoder_tb;

  localparam int              IDLE_LIMIT   = 4000;
  localparam int              DRAIN_CYCLES = 6;
  localparam int              ITEMS_TOTAL  = 1550;
  localparam int              LONG_HOLD    = 400;
  localparam pebd_pkg::tick_t TICK_TOP     = '1;

  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] packed_byte
  logic        in_tuser   = 1'b0;   // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;           // [6:0] gap_ticks, [22:7] step_sum, [54:23] event_tick
  logic        out_tuser;           // [0] status
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = pebd_pkg::REG_STEP_BITS;
  logic [2:0]  cfg_data   = 3'd0;

  // decoder shadow state
  pebd_pkg::cfg_t              dec_cfg  = '{pebd_pkg::STEP_BITS_RST, pebd_pkg::GAP_BITS_RST,
                                            pebd_pkg::SIGN_MAG_RST};
  logic                        ev_open  = 1'b0;
  logic [pebd_pkg::GAP_W-1:0]  ev_gap   = '0;
  logic [pebd_pkg::STEP_W-1:0] ev_step  = '0;
  pebd_pkg::tick_t             tick_acc = '0;

  pebd_pkg::result_t expected_events[$];

  int fail_count  = 0;
  int item_count  = 0;
  int burst_left  = 0;
  bit gaps_off    = 1'b0;
  int hold_req    = 0;
  int hold_cnt    = 0;
  int seg_left    = 0;
  int seg_mode    = RX_OPEN;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  packed_event_byte_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic logic [pebd_pkg::STEP_W-1:0] level_step_of(logic [7:0] b,
                                                                pebd_pkg::cfg_t c);
    logic [15:0] field_mask;
    logic [15:0] raw;
    logic [15:0] top;
    if (c.step_bits == 3'd0) return 16'h0000;
    field_mask = (16'h0001 << c.step_bits) - 16'h0001;
    raw        = {8'h00, b} & field_mask;
    top        = 16'h0001 << (c.step_bits - 3'd1);
    if (c.sign_mag_mode) begin
      if ((raw & top) != 16'h0000) return 16'h0000 - (raw & (top - 16'h0001));
      return raw & (top - 16'h0001);
    end
    if ((raw & top) != 16'h0000) return raw | ~field_mask;
    return raw;
  endfunction

  function automatic logic [7:0] gap_field_mask(pebd_pkg::cfg_t c);
    logic [15:0] m;
    m = ((16'h0001 << c.gap_bits) - 16'h0001) << c.step_bits;
    return m[7:0];
  endfunction

  function automatic logic [pebd_pkg::GAP_W-1:0] tick_gap_of(logic [7:0] b,
                                                            pebd_pkg::cfg_t c);
    logic [7:0] g;
    g = (b & gap_field_mask(c)) >> c.step_bits;
    return g[pebd_pkg::GAP_W-1:0];
  endfunction

  function automatic logic [7:0] pick_byte(bit opens);
    logic [7:0] b;
    logic [7:0] gm;
    b  = 8'($urandom_range(0, 255));
    gm = gap_field_mask(dec_cfg);
    if (opens && gm != 8'h00 && (b & gm) == 8'h00) b = b | (8'h01 << dec_cfg.step_bits);
    if (!opens) b = b & ~gm;
    return b;
  endfunction

  task automatic predict_item(input logic kind, input logic [7:0] b);
    logic [pebd_pkg::STEP_W-1:0]  st;
    logic [pebd_pkg::GAP_W-1:0]   g;
    logic [pebd_pkg::TICK_BITS:0] sum;
    if (kind == pebd_pkg::KIND_END) begin
      if (ev_open) begin
        expected_events.push_back('{ev_gap, ev_step, tick_acc[pebd_pkg::EV_TICK_W-1:0],
                                    pebd_pkg::STATUS_EVENT, 1'b1});
      end else begin
        expected_events.push_back('{7'd0, 16'd0, 32'd0, pebd_pkg::STATUS_EMPTY, 1'b1});
      end
      ev_open  = 1'b0;
      ev_gap   = '0;
      ev_step  = '0;
      tick_acc = '0;
      return;
    end
    st = level_step_of(b, dec_cfg);
    g  = tick_gap_of(b, dec_cfg);
    if (g == '0) begin
      if (ev_open) ev_step = ev_step + st;
      return;
    end
    if (ev_open) begin
      expected_events.push_back('{ev_gap, ev_step, tick_acc[pebd_pkg::EV_TICK_W-1:0],
                                  pebd_pkg::STATUS_EVENT, 1'b0});
    end
    sum      = {1'b0, tick_acc} + (pebd_pkg::TICK_BITS + 1)'(g);
    tick_acc = sum[pebd_pkg::TICK_BITS] ? TICK_TOP : sum[pebd_pkg::TICK_BITS-1:0];
    ev_open  = 1'b1;
    ev_gap   = g;
    ev_step  = st;
  endtask

  task automatic send_item(input logic kind, input logic [7:0] b);
    int gap_len;
    if (!gaps_off && burst_left <= 0) begin
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_item(kind, b);
    burst_left--;
    item_count++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input int sb, input int gb, input int sm);
    logic [1:0] regs[3];
    logic [2:0] vals[3];
    regs = '{pebd_pkg::REG_STEP_BITS, pebd_pkg::REG_GAP_BITS, pebd_pkg::REG_SIGN_MAG};
    vals = '{3'(sb), 3'(gb), 3'(sm & 1)};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (regs[i])
        pebd_pkg::REG_STEP_BITS: dec_cfg.step_bits     = vals[i];
        pebd_pkg::REG_GAP_BITS:  dec_cfg.gap_bits      = vals[i];
        pebd_pkg::REG_SIGN_MAG:  dec_cfg.sign_mag_mode = vals[i][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(pebd_pkg::KIND_END,  8'h00);
    send_item(pebd_pkg::KIND_DATA, 8'h00);
    send_item(pebd_pkg::KIND_DATA, 8'hFF);
    send_item(pebd_pkg::KIND_DATA, 8'h03);
    send_item(pebd_pkg::KIND_DATA, 8'h01);
    send_item(pebd_pkg::KIND_DATA, 8'h02);
    send_item(pebd_pkg::KIND_DATA, 8'h04);
    send_item(pebd_pkg::KIND_DATA, 8'hFC);
    send_item(pebd_pkg::KIND_END,  8'hFF);
    send_item(pebd_pkg::KIND_END,  8'h5A);
  endtask

  task automatic test_field_widths();
    settle();
    apply_config(7, 7, 0);
    send_item(pebd_pkg::KIND_DATA, 8'h80);
    send_item(pebd_pkg::KIND_DATA, 8'h7F);
    send_item(pebd_pkg::KIND_DATA, 8'h40);
    send_item(pebd_pkg::KIND_DATA, 8'hFF);
    send_item(pebd_pkg::KIND_END,  8'h00);
    settle();
    apply_config(1, 7, 1);
    send_item(pebd_pkg::KIND_DATA, 8'h03);
    send_item(pebd_pkg::KIND_DATA, 8'h01);
    send_item(pebd_pkg::KIND_DATA, 8'hFE);
    send_item(pebd_pkg::KIND_END,  8'hAA);
    settle();
    apply_config(0, 3, 0);
    send_item(pebd_pkg::KIND_DATA, 8'h07);
    send_item(pebd_pkg::KIND_DATA, 8'hF8);
    send_item(pebd_pkg::KIND_END,  8'h00);
    settle();
    apply_config(4, 0, 1);
    send_item(pebd_pkg::KIND_DATA, 8'hFF);
    send_item(pebd_pkg::KIND_DATA, 8'h0F);
    send_item(pebd_pkg::KIND_END,  8'h00);
  endtask

  // push the merged step past +32767 so the 16-bit sum wraps
  task automatic test_step_wrap();
    settle();
    apply_config(7, 1, 0);
    send_item(pebd_pkg::KIND_DATA, 8'hBF);
    repeat (531) send_item(pebd_pkg::KIND_DATA, 8'h3F);
    send_item(pebd_pkg::KIND_DATA, 8'hC0);
    send_item(pebd_pkg::KIND_DATA, 8'h40);
    send_item(pebd_pkg::KIND_END,  8'h00);
  endtask

  task automatic test_backpressure();
    settle();
    apply_config(2, 6, 0);
    hold_req = LONG_HOLD;
    gaps_off = 1'b1;
    repeat (80) send_item(pebd_pkg::KIND_DATA, pick_byte(1'b1));
    gaps_off = 1'b0;
    send_item(pebd_pkg::KIND_END, 8'h00);
  endtask

  task automatic test_random_streams();
    int corner_sb[8] = '{7, 7, 1, 1, 0, 0, 7, 4};
    int corner_gb[8] = '{7, 7, 1, 7, 7, 0, 0, 4};
    int corner_sm[8] = '{0, 1, 1, 0, 0, 1, 0, 1};
    int phase;
    int quota;
    int len;
    phase = 0;
    while (item_count < ITEMS_TOTAL) begin
      settle();
      if (phase < 8) begin
        apply_config(corner_sb[phase], corner_gb[phase], corner_sm[phase]);
      end else begin
        apply_config($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 1));
      end
      quota = item_count + $urandom_range(50, 110);
      while (item_count < quota && item_count < ITEMS_TOTAL) begin
        if ($urandom_range(0, 9) < 8) begin
          send_item(pebd_pkg::KIND_DATA, pick_byte(1'b1));
          len = $urandom_range(0, 12);
          repeat (len) send_item(pebd_pkg::KIND_DATA, pick_byte(1'($urandom_range(0, 1))));
          if ($urandom_range(0, 7) != 0) begin
            send_item(pebd_pkg::KIND_END, 8'($urandom_range(0, 255)));
          end
        end else begin
          send_item(($urandom_range(0, 3) == 0) ? pebd_pkg::KIND_END : pebd_pkg::KIND_DATA,
                    8'($urandom_range(0, 255)));
        end
      end
      phase++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      if (seg_left <= 0) begin
        seg_mode = $urandom_range(RX_OPEN, RX_SPARSE);
        seg_left = $urandom_range(10, 150);
      end
      seg_left--;
      case (seg_mode)
        RX_OPEN: out_tready <= 1'b1;
        RX_COIN: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pebd_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_events.size() == 0) begin
        $error("result with no request pending: tdata %h tuser %b tlast %b",
               out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        check_field("gap_ticks", longint'(want.gap_ticks), longint'(out_tdata[6:0]));
        check_field("step_sum", longint'($signed(want.step_sum)),
                    longint'($signed(out_tdata[22:7])));
        check_field("event_tick", longint'(want.event_tick), longint'(out_tdata[54:23]));
        check_field("status", longint'(want.status), longint'(out_tuser));
        check_field("last_flag", longint'(want.last_flag), longint'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_field_widths();
    test_step_wrap();
    test_backpressure();
    test_random_streams();
    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
